[rtl/clook_pkg.sv]
// Shared types and constants of the C-LOOK disk scheduler.
package clook_pkg;

	localparam int CYL_W     = 16;
	localparam int MOVE_W    = 24;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_START_HEAD = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_SWEEP_UP   = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_SPLIT_RD,
		ST_SPLIT_CMP,
		ST_SRV_SETUP,
		ST_SRV_RD,
		ST_SRV_CALC
	} state_t;

	typedef struct packed {
		logic              lt;
		logic [CYL_W-1:0]  diff;
		logic [MOVE_W-1:0] sum;
	} alu_res_t;

endpackage

[rtl/clook_disk_scheduler.sv]
// Top level of the C-LOOK disk scheduler: sequencer, registers and output stage.
//
// Requests enter on the s_ channel, one cylinder per transaction; tlast marks
// the last request of a batch. Each request is insertion-sorted into a memory:
// every stored entry larger than the request moves up one place, one at a
// time through the single read port of the memory.
// s_tready is high only while the sequencer waits for a request.
// A request that arrives with MAX_REQUESTS stored is dropped, but tlast still
// starts the schedule. After the last request the block scans for the split
// point entry by entry, passes a setup state and then emits the results one
// at a time, each after a read of the store: the served cylinder, the running
// movement and tlast on the final result. A stalled receiver holds the output
// register and the sequencer waits with it; the next batch may be accepted
// while the last result of a schedule is still pending.
// Configuration (start head, sweep direction) comes through cfg_we, cfg_addr and
// cfg_wdata; the user writes it only while the block is idle, unchecked by it.
// Reset empties the request store and sets start head 0 and sweep up.
module clook_disk_scheduler #(
	parameter int MAX_REQUESTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] cylinder
	input  logic        s_tlast,    // final_request
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // [15:0] served_cylinder, [39:16] movement_so_far
	output logic        m_tlast,    // last_served
	input  logic        cfg_we,
	input  logic [clook_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [15:0] cfg_wdata
);

	localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int CY = clook_pkg::CYL_W;
	localparam int MW = clook_pkg::MOVE_W;

	clook_pkg::state_t state_q, state_d;

	logic [CY-1:0] start_head_q;
	logic          sweep_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] split_q;
	logic [CW-1:0] served_q;
	logic          phase_q;
	logic          jump_q;
	logic [CY-1:0] cyl_q;
	logic          fin_q;
	logic [CY-1:0] head_q;
	logic [MW-1:0] move_q;

	logic          out_valid_q;
	logic [CY-1:0] out_cyl_q;
	logic [MW-1:0] out_move_q;
	logic          out_last_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [CY-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [CY-1:0] mem_rdata;

	logic [CY-1:0] alu_a;
	logic [CY-1:0] alu_b;
	logic [MW-1:0] alu_acc;
	logic          alu_cin;
	clook_pkg::alu_res_t alu_res;

	logic          accept;
	logic          out_free;
	logic          out_load;
	logic          not_full;
	logic          last_res;
	logic [CW-1:0] pos_m1;
	logic [CW-1:0] pos_m2;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == clook_pkg::ST_SRV_CALC) && out_free;
	assign not_full = count_q < CW'(MAX_REQUESTS);
	assign last_res = served_q == (count_q - CW'(1));
	assign pos_m1   = pos_q - CW'(1);
	assign pos_m2   = pos_q - CW'(2);

	assign s_tready = state_q == clook_pkg::ST_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_move_q, out_cyl_q};
	assign m_tlast  = out_last_q;

	clook_mem #(
		.DEPTH(MAX_REQUESTS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	clook_alu u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.acc(alu_acc),
		.cin(alu_cin),
		.res(alu_res)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clook_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (not_full) begin
						state_d = clook_pkg::ST_INS_RD;
					end else if (s_tlast) begin
						state_d = clook_pkg::ST_SPLIT_RD;
					end
				end
			end
			clook_pkg::ST_INS_RD: begin
				if (pos_q == '0) begin
					state_d = fin_q ? clook_pkg::ST_SPLIT_RD : clook_pkg::ST_IDLE;
				end else begin
					state_d = clook_pkg::ST_INS_CMP;
				end
			end
			clook_pkg::ST_INS_CMP: begin
				if (alu_res.lt) begin
					state_d = (pos_q == CW'(1)) ? clook_pkg::ST_INS_RD : clook_pkg::ST_INS_CMP;
				end else begin
					state_d = fin_q ? clook_pkg::ST_SPLIT_RD : clook_pkg::ST_IDLE;
				end
			end
			clook_pkg::ST_SPLIT_RD: begin
				state_d = (idx_q == count_q) ? clook_pkg::ST_SRV_SETUP
				                             : clook_pkg::ST_SPLIT_CMP;
			end
			clook_pkg::ST_SPLIT_CMP: begin
				state_d = alu_res.lt ? clook_pkg::ST_SPLIT_RD : clook_pkg::ST_SRV_SETUP;
			end
			clook_pkg::ST_SRV_SETUP: begin
				state_d = clook_pkg::ST_SRV_RD;
			end
			clook_pkg::ST_SRV_RD: begin
				state_d = clook_pkg::ST_SRV_CALC;
			end
			clook_pkg::ST_SRV_CALC: begin
				if (out_free) begin
					state_d = last_res ? clook_pkg::ST_IDLE : clook_pkg::ST_SRV_RD;
				end
			end
			default: begin
				state_d = clook_pkg::ST_IDLE;
			end
		endcase
	end

	// Memory and shared unit control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[AW-1:0];
		mem_wdata = cyl_q;
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		alu_a     = cyl_q;
		alu_b     = mem_rdata;
		alu_acc   = move_q;
		alu_cin   = 1'b0;
		unique case (state_q)
			clook_pkg::ST_INS_RD: begin
				if (pos_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = pos_m1[AW-1:0];
				end
			end
			clook_pkg::ST_INS_CMP: begin
				// The entry below moves up while the one beneath it is fetched.
				mem_we = 1'b1;
				if (alu_res.lt) begin
					mem_wdata = mem_rdata;
					if (pos_q != CW'(1)) begin
						mem_re    = 1'b1;
						mem_raddr = pos_m2[AW-1:0];
					end
				end
			end
			clook_pkg::ST_SPLIT_RD: begin
				mem_re = idx_q != count_q;
			end
			clook_pkg::ST_SPLIT_CMP: begin
				alu_a = mem_rdata;
				alu_b = start_head_q;
			end
			clook_pkg::ST_SRV_RD: begin
				mem_re = 1'b1;
			end
			clook_pkg::ST_SRV_CALC: begin
				alu_a   = head_q;
				alu_b   = mem_rdata;
				alu_cin = jump_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= clook_pkg::ST_IDLE;
			start_head_q <= '0;
			sweep_q      <= 1'b1;
			count_q      <= '0;
			pos_q        <= '0;
			idx_q        <= '0;
			split_q      <= '0;
			served_q     <= '0;
			phase_q      <= 1'b0;
			jump_q       <= 1'b0;
			cyl_q        <= '0;
			fin_q        <= 1'b0;
			head_q       <= '0;
			move_q       <= '0;
			out_valid_q  <= 1'b0;
			out_cyl_q    <= '0;
			out_move_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_addr)
					clook_pkg::REG_START_HEAD: start_head_q <= cfg_wdata;
					clook_pkg::REG_SWEEP_UP:   sweep_q      <= cfg_wdata[0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				clook_pkg::ST_IDLE: begin
					if (accept) begin
						cyl_q <= s_tdata;
						fin_q <= s_tlast;
						pos_q <= count_q;
						idx_q <= '0;
					end
				end
				clook_pkg::ST_INS_RD: begin
					if (pos_q == '0) begin
						count_q <= count_q + CW'(1);
					end
				end
				clook_pkg::ST_INS_CMP: begin
					if (alu_res.lt) begin
						pos_q <= pos_m1;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				clook_pkg::ST_SPLIT_RD: begin
					if (idx_q == count_q) begin
						split_q <= count_q;
					end
				end
				clook_pkg::ST_SPLIT_CMP: begin
					if (alu_res.lt) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						split_q <= idx_q;
					end
				end
				clook_pkg::ST_SRV_SETUP: begin
					head_q   <= start_head_q;
					move_q   <= '0;
					served_q <= '0;
					// An empty first run starts with the return jump at once.
					if (sweep_q) begin
						if (split_q != count_q) begin
							idx_q   <= split_q;
							phase_q <= 1'b0;
							jump_q  <= 1'b0;
						end else begin
							idx_q   <= '0;
							phase_q <= 1'b1;
							jump_q  <= 1'b1;
						end
					end else begin
						if (split_q != '0) begin
							idx_q   <= split_q - CW'(1);
							phase_q <= 1'b0;
							jump_q  <= 1'b0;
						end else begin
							idx_q   <= count_q - CW'(1);
							phase_q <= 1'b1;
							jump_q  <= 1'b1;
						end
					end
				end
				clook_pkg::ST_SRV_CALC: begin
					if (out_free) begin
						out_cyl_q   <= mem_rdata;
						out_move_q  <= alu_res.sum;
						out_last_q  <= last_res;
						head_q      <= mem_rdata;
						move_q      <= alu_res.sum;
						served_q    <= served_q + CW'(1);
						if (last_res) begin
							count_q <= '0;
							jump_q  <= 1'b0;
						end else if (sweep_q) begin
							if (!phase_q && (idx_q + CW'(1) == count_q)) begin
								idx_q   <= '0;
								phase_q <= 1'b1;
								jump_q  <= 1'b1;
							end else begin
								idx_q  <= idx_q + CW'(1);
								jump_q <= 1'b0;
							end
						end else begin
							if (!phase_q && (idx_q == '0)) begin
								idx_q   <= count_q - CW'(1);
								phase_q <= 1'b1;
								jump_q  <= 1'b1;
							end else begin
								idx_q  <= idx_q - CW'(1);
								jump_q <= 1'b0;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/clook_mem.sv]
// Request store: one write port and one registered read port.
module clook_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [clook_pkg::CYL_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [clook_pkg::CYL_W-1:0] rdata
);

	logic [clook_pkg::CYL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/clook_alu.sv]
// Shared compare, distance and movement accumulate unit.
module clook_alu (
	input  logic [clook_pkg::CYL_W-1:0]  a,
	input  logic [clook_pkg::CYL_W-1:0]  b,
	input  logic [clook_pkg::MOVE_W-1:0] acc,
	input  logic                         cin,
	output clook_pkg::alu_res_t          res
);

	always_comb begin
		res.lt   = a < b;
		res.diff = res.lt ? (b - a) : (a - b);
		res.sum  = acc + clook_pkg::MOVE_W'(res.diff) + clook_pkg::MOVE_W'(cin);
	end

endmodule
